FILE: rtl/ttpm_pkg.sv
`default_nettype none

package ttpm_pkg;

  // port and register widths
  localparam int IO_W        = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int HALF_W      = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_VTX     = 4;
  localparam int VTX_IDX_W   = $clog2(NUM_VTX);

  // register indexes
  localparam int CFG_GLOBAL_BASE = NUM_VTX;
  localparam int CFG_NUM_REGS    = 2 * NUM_VTX;

  // fixed point format
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;

  // intermediate widths
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int AREA_W  = SQ_W + 1;
  localparam int SPLIT_W = DIFF_W;
  localparam int PART_W  = SPLIT_W + 1 + COORD_W;
  localparam int PROD_W  = AREA_W + COORD_W;
  localparam int SUM_W   = PROD_W + 2;

  // divider widths
  localparam int Q_W     = 32;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN_W   = AREA_W + 1;
  localparam int REM_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int DIV_LAT = Q_W + 2;

  // areas computed per point
  localparam int NUM_AREAS = 5;
  localparam int A_TRI     = 0;
  localparam int A_W0      = 1;
  localparam int A_W1      = 2;
  localparam int A_W2      = 3;
  localparam int A_TGT     = 4;

  // divider lanes
  localparam int NUM_DIV = 3;
  localparam int DV_X    = 0;
  localparam int DV_Y    = 1;
  localparam int DV_JAC  = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [SQ_W-1:0]    sq_t;
  typedef logic signed [AREA_W-1:0]  area_t;
  typedef logic signed [PART_W-1:0]  part_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  typedef vtx_t [NUM_VTX-1:0] quad_t;
  typedef vtx_t [2:0] tri_t;

  // edge vectors of one signed area: ux*vy - uy*vx
  typedef struct packed {
    diff_t ux;
    diff_t vy;
    diff_t uy;
    diff_t vx;
  } area_d_t;

  typedef struct packed {
    sq_t m;
    sq_t n;
  } area_p_t;

  typedef struct packed {
    part_t hi;
    part_t lo;
  } pp_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [Q_W-1:0] q;
  } div_res_t;

  typedef struct packed {
    logic signed [IO_W-1:0] mapped_x;
    logic signed [IO_W-1:0] mapped_y;
    logic signed [IO_W-1:0] jacobian;
    logic                   second_triangle;
    logic                   degenerate;
  } out_t;

  function automatic vtx_t unpack_vtx(logic [CFG_DATA_W-1:0] v);
    vtx_t r;
    r.x = $signed(v[HALF_W +: COORD_W]);
    r.y = $signed(v[0 +: COORD_W]);
    return r;
  endfunction

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic area_d_t mk_area_d(vtx_t p0, vtx_t p1, vtx_t p2);
    area_d_t r;
    r.ux = sub_c(p1.x, p0.x);
    r.vy = sub_c(p2.y, p0.y);
    r.uy = sub_c(p1.y, p0.y);
    r.vx = sub_c(p2.x, p0.x);
    return r;
  endfunction

  function automatic area_p_t mul_area(area_d_t d);
    area_p_t r;
    r.m = sq_t'(d.ux) * sq_t'(d.vy);
    r.n = sq_t'(d.uy) * sq_t'(d.vx);
    return r;
  endfunction

  // triangle 0-1-2 or triangle 0-2-3
  function automatic tri_t pick_tri(quad_t q, logic second);
    tri_t t;
    t[0] = q[0];
    t[1] = second ? q[2] : q[1];
    t[2] = second ? q[3] : q[2];
    return t;
  endfunction

  // weight split into low unsigned and high signed halves, each times a coordinate
  function automatic pp_t mul_split(area_t w, coord_t b);
    pp_t r;
    logic signed [SPLIT_W:0]        lo;
    logic signed [AREA_W-SPLIT_W-1:0] hi;
    lo = $signed({1'b0, w[SPLIT_W-1:0]});
    hi = w[AREA_W-1:SPLIT_W];
    r.lo = part_t'(lo) * part_t'(b);
    r.hi = part_t'(hi) * part_t'(b);
    return r;
  endfunction

  // apply sign and saturate to a signed width of bits
  function automatic logic signed [IO_W-1:0] sat_div(div_res_t r, int unsigned bits);
    logic [Q_W:0]          lim;
    logic [Q_W:0]          qx;
    logic [Q_W:0]          mag;
    logic signed [Q_W+1:0] val;
    lim = (Q_W+1)'(1) << (bits - 1);
    qx  = {1'b0, r.q};
    if (r.neg) begin
      mag = (r.ovf || qx > lim) ? lim : qx;
    end else begin
      mag = (r.ovf || qx >= lim) ? lim - (Q_W+1)'(1) : qx;
    end
    val = r.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return val[IO_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ttpm_if.sv
`default_nettype none

interface ttpm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [ttpm_pkg::IO_W-1:0]       point_x;
  logic signed [ttpm_pkg::IO_W-1:0]       point_y;

  modport source(output valid, kind, point_x, point_y, input ready);
  modport sink(input valid, kind, point_x, point_y, output ready);
endinterface

interface ttpm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ttpm_pkg::IO_W-1:0]       mapped_x;
  logic signed [ttpm_pkg::IO_W-1:0]       mapped_y;
  logic signed [ttpm_pkg::IO_W-1:0]       jacobian;
  logic                                   second_triangle;
  logic                                   degenerate;

  modport source(output valid, mapped_x, mapped_y, jacobian, second_triangle, degenerate,
                 input ready);
  modport sink(input valid, mapped_x, mapped_y, jacobian, second_triangle, degenerate,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/ttpm_div.sv
`default_nettype none

// pipelined rounding divider, one quotient bit per stage
module ttpm_div (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire ttpm_pkg::sum_t      num,
  input  wire ttpm_pkg::area_t     den,
  output ttpm_pkg::div_res_t       res
);

  typedef struct packed {
    logic [ttpm_pkg::REM_W-1:0] rem;
    logic [ttpm_pkg::DEN_W-1:0] d;
    logic                       neg;
    logic                       ovf;
    logic [ttpm_pkg::Q_W-1:0]   q;
  } dv_t;

  logic [ttpm_pkg::SUM_W-1:0]  mag_n;
  logic [ttpm_pkg::AREA_W-1:0] mag_d;
  dv_t                         prep_nxt;
  dv_t                         prep_r;
  dv_t                         chk_nxt;
  dv_t                         stg_r [ttpm_pkg::Q_W+1];

  // magnitudes; 2|n|+|d| over 2|d| rounds half away from zero
  always_comb begin
    mag_n = num[ttpm_pkg::SUM_W-1] ? ttpm_pkg::SUM_W'(-num) : ttpm_pkg::SUM_W'(num);
    mag_d = den[ttpm_pkg::AREA_W-1] ? ttpm_pkg::AREA_W'(-den) : ttpm_pkg::AREA_W'(den);
    prep_nxt     = '0;
    prep_nxt.rem = ttpm_pkg::REM_W'({mag_n, 1'b0}) + ttpm_pkg::REM_W'(mag_d);
    prep_nxt.d   = {mag_d, 1'b0};
    prep_nxt.neg = num[ttpm_pkg::SUM_W-1] ^ den[ttpm_pkg::AREA_W-1];
  end

  // quotient too large for the bits produced below
  always_comb begin
    chk_nxt     = prep_r;
    chk_nxt.ovf = prep_r.rem >= (ttpm_pkg::REM_W'(prep_r.d) << ttpm_pkg::Q_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r   <= prep_nxt;
      stg_r[0] <= chk_nxt;
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar j = 0; j < ttpm_pkg::Q_W; j++) begin : g_bit
    logic [ttpm_pkg::REM_W-1:0] dsh;
    logic                       ge;
    dv_t                        bit_nxt;

    always_comb begin
      dsh     = ttpm_pkg::REM_W'(stg_r[j].d) << (ttpm_pkg::Q_W - 1 - j);
      ge      = stg_r[j].rem >= dsh;
      bit_nxt = stg_r[j];
      if (ge) begin
        bit_nxt.rem = stg_r[j].rem - dsh;
      end
      bit_nxt.q[ttpm_pkg::Q_W-1-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[j+1] <= bit_nxt;
      end
    end
  end

  assign res.neg = stg_r[ttpm_pkg::Q_W].neg;
  assign res.ovf = stg_r[ttpm_pkg::Q_W].ovf;
  assign res.q   = stg_r[ttpm_pkg::Q_W].q;

endmodule

`default_nettype wire

FILE: rtl/twin_triangle_point_map.sv
// Maps a point between a local and a global quadrilateral, each split along
// the diagonal from vertex 0 to vertex 2 into two triangles.
// Input channel in_chan: kind (0 local to global, 1 global to local) and the
// source point in signed Q16.16. Result channel out_chan: mapped point,
// area-ratio jacobian, triangle used and a degenerate flag. Both use
// valid/ready; a transaction happens when both are high.
// Configuration: cfg_we with cfg_index 0..3 writes local vertices 0..3,
// 4..7 global vertices 0..3 (x in bits 63:32, y in 31:0); other indexes are
// ignored. Write only while no transaction is in flight.
// Throughput: one point per cycle while the pipeline is not held by a stall.
// A point passes 10 stages of area and weight math (33x33 and 34x32
// multipliers), then 34 stages of the rounding divider: a magnitude stage, an
// overflow check stage, then one quotient bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and clears all vertices.
// When the receiver stalls, the finished result holds in the output register,
// one more lands in a skid register, and then the whole pipeline holds and
// in_chan.ready drops; nothing is lost or repeated.
`default_nettype none

module twin_triangle_point_map (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ttpm_in_if.sink                               in_chan,
  ttpm_out_if.source                            out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [ttpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int FRONT = 10;
  localparam int TOT   = FRONT + ttpm_pkg::DIV_LAT;

  // vertex registers
  logic [ttpm_pkg::CFG_DATA_W-1:0] lvtx_r [ttpm_pkg::NUM_VTX];
  logic [ttpm_pkg::CFG_DATA_W-1:0] gvtx_r [ttpm_pkg::NUM_VTX];
  ttpm_pkg::quad_t                 lquad;
  ttpm_pkg::quad_t                 gquad;

  // pipeline control
  logic               pipe_en;
  logic [TOT-1:0]     vld_r;
  logic [TOT-1:0]     vld_nxt;

  // front stage payload
  logic               kind1_r, kind2_r, kind3_r, kind4_r, kind5_r, kind6_r, kind7_r;
  ttpm_pkg::vtx_t     p1_r, p2_r, p3_r, p4_r;
  ttpm_pkg::area_d_t  ind_d_r;
  ttpm_pkg::area_p_t  ind_p_r;
  logic               sec4_r, sec5_r, sec6_r, sec7_r, sec8_r, sec9_r, sec10_r;
  ttpm_pkg::area_d_t  ad_r [ttpm_pkg::NUM_AREAS];
  ttpm_pkg::area_p_t  ap_r [ttpm_pkg::NUM_AREAS];
  ttpm_pkg::area_t    ar_r [ttpm_pkg::NUM_AREAS];
  logic               deg7_r, deg8_r, deg9_r, deg10_r;
  ttpm_pkg::pp_t      part_r [3][2];
  ttpm_pkg::prod_t    prod_r [3][2];
  ttpm_pkg::area_t    ar8_r, ta8_r, ar9_r, ta9_r, den10_r;
  ttpm_pkg::sum_t     num10_r [ttpm_pkg::NUM_DIV];

  ttpm_pkg::quad_t    src2, src5, dst5, dst8;
  ttpm_pkg::tri_t     ts5, td5, td8;
  ttpm_pkg::area_t    ind4;

  // divider side
  ttpm_pkg::div_res_t           dres [ttpm_pkg::NUM_DIV];
  logic [ttpm_pkg::DIV_LAT-1:0] deg_sh_r;
  logic [ttpm_pkg::DIV_LAT-1:0] sec_sh_r;

  // output side
  ttpm_pkg::out_t     res;
  ttpm_pkg::out_t     out_r;
  ttpm_pkg::out_t     skid_r;
  logic               out_valid_r;
  logic               skid_valid_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ttpm_pkg::NUM_VTX; i++) begin
        lvtx_r[i] <= '0;
        gvtx_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index < ttpm_pkg::CFG_IDX_W'(ttpm_pkg::CFG_GLOBAL_BASE)) begin
        lvtx_r[cfg_index[ttpm_pkg::VTX_IDX_W-1:0]] <= cfg_wdata;
      end else if (cfg_index < ttpm_pkg::CFG_IDX_W'(ttpm_pkg::CFG_NUM_REGS)) begin
        gvtx_r[cfg_index[ttpm_pkg::VTX_IDX_W-1:0]] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ttpm_pkg::NUM_VTX; i++) begin
      lquad[i] = ttpm_pkg::unpack_vtx(lvtx_r[i]);
      gquad[i] = ttpm_pkg::unpack_vtx(gvtx_r[i]);
    end
  end

  // pipeline moves as a whole while the skid register is free
  assign pipe_en       = !skid_valid_r;
  assign in_chan.ready = pipe_en;
  assign vld_nxt       = {vld_r[TOT-2:0], in_chan.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= vld_nxt;
    end
  end

  // source and target quads, triangle selection
  always_comb begin
    src2 = kind1_r ? gquad : lquad;
    ind4 = ttpm_pkg::area_t'(ind_p_r.m) - ttpm_pkg::area_t'(ind_p_r.n);
    src5 = kind4_r ? gquad : lquad;
    dst5 = kind4_r ? lquad : gquad;
    ts5  = ttpm_pkg::pick_tri(src5, sec4_r);
    td5  = ttpm_pkg::pick_tri(dst5, sec4_r);
    dst8 = kind7_r ? lquad : gquad;
    td8  = ttpm_pkg::pick_tri(dst8, sec7_r);
  end

  // front stages: side test, areas, weighted sums
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // input register
      kind1_r <= in_chan.kind;
      p1_r.x  <= $signed(in_chan.point_x[ttpm_pkg::COORD_W-1:0]);
      p1_r.y  <= $signed(in_chan.point_y[ttpm_pkg::COORD_W-1:0]);
      // side of the diagonal: edge vectors
      kind2_r <= kind1_r;
      p2_r    <= p1_r;
      ind_d_r <= ttpm_pkg::mk_area_d(src2[0], p1_r, src2[2]);
      // side of the diagonal: products
      kind3_r <= kind2_r;
      p3_r    <= p2_r;
      ind_p_r <= ttpm_pkg::mul_area(ind_d_r);
      // side of the diagonal: sign
      kind4_r <= kind3_r;
      p4_r    <= p3_r;
      sec4_r  <= ind4[ttpm_pkg::AREA_W-1] || (ind4 == '0);
      // triangle areas: edge vectors
      kind5_r <= kind4_r;
      sec5_r  <= sec4_r;
      ad_r[ttpm_pkg::A_TRI] <= ttpm_pkg::mk_area_d(ts5[0], ts5[1], ts5[2]);
      ad_r[ttpm_pkg::A_W0]  <= ttpm_pkg::mk_area_d(p4_r, ts5[1], ts5[2]);
      ad_r[ttpm_pkg::A_W1]  <= ttpm_pkg::mk_area_d(p4_r, ts5[2], ts5[0]);
      ad_r[ttpm_pkg::A_W2]  <= ttpm_pkg::mk_area_d(p4_r, ts5[0], ts5[1]);
      ad_r[ttpm_pkg::A_TGT] <= ttpm_pkg::mk_area_d(td5[0], td5[1], td5[2]);
      // triangle areas: products
      kind6_r <= kind5_r;
      sec6_r  <= sec5_r;
      for (int i = 0; i < ttpm_pkg::NUM_AREAS; i++) begin
        ap_r[i] <= ttpm_pkg::mul_area(ad_r[i]);
      end
      // triangle areas: differences
      kind7_r <= kind6_r;
      sec7_r  <= sec6_r;
      for (int i = 0; i < ttpm_pkg::NUM_AREAS; i++) begin
        ar_r[i] <= ttpm_pkg::area_t'(ap_r[i].m) - ttpm_pkg::area_t'(ap_r[i].n);
      end
      deg7_r  <= (ttpm_pkg::area_t'(ap_r[ttpm_pkg::A_TRI].m) ==
                  ttpm_pkg::area_t'(ap_r[ttpm_pkg::A_TRI].n));
      // weights times target vertices, split partial products
      sec8_r  <= sec7_r;
      deg8_r  <= deg7_r;
      ar8_r   <= ar_r[ttpm_pkg::A_TRI];
      ta8_r   <= ar_r[ttpm_pkg::A_TGT];
      for (int k = 0; k < 3; k++) begin
        part_r[k][0] <= ttpm_pkg::mul_split(ar_r[ttpm_pkg::A_W0 + k], td8[k].x);
        part_r[k][1] <= ttpm_pkg::mul_split(ar_r[ttpm_pkg::A_W0 + k], td8[k].y);
      end
      // partial products joined
      sec9_r  <= sec8_r;
      deg9_r  <= deg8_r;
      ar9_r   <= ar8_r;
      ta9_r   <= ta8_r;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 2; c++) begin
          prod_r[k][c] <= (ttpm_pkg::prod_t'(part_r[k][c].hi) <<< ttpm_pkg::SPLIT_W) +
                          ttpm_pkg::prod_t'(part_r[k][c].lo);
        end
      end
      // numerators for the three divisions
      sec10_r <= sec9_r;
      deg10_r <= deg9_r;
      den10_r <= ar9_r;
      num10_r[ttpm_pkg::DV_X]   <= ttpm_pkg::sum_t'(prod_r[0][0]) +
                                   ttpm_pkg::sum_t'(prod_r[1][0]) +
                                   ttpm_pkg::sum_t'(prod_r[2][0]);
      num10_r[ttpm_pkg::DV_Y]   <= ttpm_pkg::sum_t'(prod_r[0][1]) +
                                   ttpm_pkg::sum_t'(prod_r[1][1]) +
                                   ttpm_pkg::sum_t'(prod_r[2][1]);
      num10_r[ttpm_pkg::DV_JAC] <= ttpm_pkg::sum_t'(ta9_r) <<< ttpm_pkg::FRAC_W;
      // flags alongside the divider
      deg_sh_r <= {deg_sh_r[ttpm_pkg::DIV_LAT-2:0], deg10_r};
      sec_sh_r <= {sec_sh_r[ttpm_pkg::DIV_LAT-2:0], sec10_r};
    end
  end

  // dividers for x, y and jacobian
  for (genvar g = 0; g < ttpm_pkg::NUM_DIV; g++) begin : g_div
    ttpm_div u_div (
      .clk (clk),
      .en  (pipe_en),
      .num (num10_r[g]),
      .den (den10_r),
      .res (dres[g])
    );
  end

  // sign, saturation and degenerate zeroing
  always_comb begin
    res.second_triangle = sec_sh_r[ttpm_pkg::DIV_LAT-1];
    res.degenerate      = deg_sh_r[ttpm_pkg::DIV_LAT-1];
    if (deg_sh_r[ttpm_pkg::DIV_LAT-1]) begin
      res.mapped_x = '0;
      res.mapped_y = '0;
      res.jacobian = '0;
    end else begin
      res.mapped_x = ttpm_pkg::sat_div(dres[ttpm_pkg::DV_X], ttpm_pkg::COORD_W);
      res.mapped_y = ttpm_pkg::sat_div(dres[ttpm_pkg::DV_Y], ttpm_pkg::COORD_W);
      res.jacobian = ttpm_pkg::sat_div(dres[ttpm_pkg::DV_JAC], ttpm_pkg::IO_W);
    end
  end

  // output register with skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= vld_r[TOT-1];
      end
    end else if (vld_r[TOT-1]) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (pipe_en) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.mapped_x        = out_r.mapped_x;
  assign out_chan.mapped_y        = out_r.mapped_y;
  assign out_chan.jacobian        = out_r.jacobian;
  assign out_chan.second_triangle = out_r.second_triangle;
  assign out_chan.degenerate      = out_r.degenerate;

  // skid register is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while output register is empty");

  // a drained skid register refills the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_chan.ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid register not drained into output register");

  // a held pipeline keeps its valid bits
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  // degenerate results carry zero values
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.degenerate) |->
      (out_r.mapped_x == '0 && out_r.mapped_y == '0 && out_r.jacobian == '0))
    else $error("degenerate result with nonzero values");

endmodule

`default_nettype wire
